FILE: rtl/gtg_pkg.sv
package gtg_pkg;

    localparam int CORDIC_ITERATIONS = 16;

    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int KP_W    = 24;
    localparam int SPD_W   = 23;
    localparam int VEL_W   = 24;
    localparam int CFG_W   = 24;
    localparam int FRAC_W  = 16;

    localparam int OFS_W   = POS_W + 1;
    localparam int PROD_W  = 2 * QUAT_W;
    localparam int OPD_W   = 35;
    localparam int WIDE_W  = 64;
    localparam int ANG_W   = 35;
    localparam int DIFF_W  = ANG_W + 1;
    localparam int ERR_W   = 34;
    localparam int ERR_LO_W = 16;
    localparam int SUM_W   = 59;
    localparam int RATE_SHIFT = 30;
    localparam int RATE_W  = SUM_W - RATE_SHIFT;

    localparam int NORM_EXP   = 60;
    localparam int NORM_STEPS = 6;
    localparam int ATAN_LAT   = 1 + NORM_STEPS + CORDIC_ITERATIONS;

    localparam int SQ_N_W    = 46;
    localparam int SQ_STEPS  = SQ_N_W / 2;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int SQ_REM_W  = SQ_ROOT_W + 3;

    localparam int DIV_NUM_W  = 40;
    localparam int DIV_STEPS  = 24;
    localparam int DIV_REM_W  = SQ_ROOT_W;

    localparam int BACK_LAT = ATAN_LAT + 5 + SQ_STEPS + 1 + DIV_STEPS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam longint ANG_PI      = 64'sd3373259426;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint ANG_TWO_PI  = 64'sd6746518852;

    localparam logic [31:0] ATAN_TAB [0:23] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    typedef enum logic [1:0] {
        CFG_KP   = 2'd0,
        CFG_LMAX = 2'd1,
        CFG_AMAX = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0]  goal_x;
        logic signed [POS_W-1:0]  goal_y;
        logic signed [POS_W-1:0]  robot_x;
        logic signed [POS_W-1:0]  robot_y;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
    } t_in_beat;

    typedef struct packed {
        logic signed [VEL_W-1:0] linear_velocity;
        logic signed [VEL_W-1:0] angular_velocity;
    } t_out_beat;

    typedef struct packed {
        logic signed [OPD_W-1:0] dx;
        logic signed [OPD_W-1:0] dy;
        logic signed [OPD_W-1:0] num;
        logic signed [OPD_W-1:0] den;
        logic                    yaw_zero;
    } t_job;

    typedef struct packed {
        logic [KP_W-1:0]  kp;
        logic [SPD_W-1:0] lmax;
        logic [SPD_W-1:0] amax;
    } t_cfg;

endpackage

FILE: rtl/gtg_front.sv
module gtg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gtg_pkg::t_in_beat i_data,
    output logic              o_push,
    input  logic              i_full,
    output gtg_pkg::t_job     o_job
);

    logic f_en;
    logic r_s1_valid, r_s2_valid;
    logic signed [gtg_pkg::OFS_W-1:0]  r_dx, r_dy;
    logic signed [gtg_pkg::PROD_W-1:0] r_pxy, r_pwz, r_pww, r_pxx, r_pyy, r_pzz, r_pxz, r_pwy;
    logic signed [gtg_pkg::OPD_W-1:0]  w_num, w_den, w_tilt, w_norm, w_tmag;
    gtg_pkg::t_job r_job;

    assign f_en    = !r_s2_valid || !i_full;
    assign o_ready = f_en;
    assign o_push  = r_s2_valid && !i_full;
    assign o_job   = r_job;

    assign w_num  = (gtg_pkg::OPD_W'(r_pxy) + gtg_pkg::OPD_W'(r_pwz)) <<< 1;
    assign w_den  = gtg_pkg::OPD_W'(r_pww) + gtg_pkg::OPD_W'(r_pxx)
                  - gtg_pkg::OPD_W'(r_pyy) - gtg_pkg::OPD_W'(r_pzz);
    assign w_tilt = (gtg_pkg::OPD_W'(r_pxz) - gtg_pkg::OPD_W'(r_pwy)) <<< 1;
    assign w_norm = gtg_pkg::OPD_W'(r_pww) + gtg_pkg::OPD_W'(r_pxx)
                  + gtg_pkg::OPD_W'(r_pyy) + gtg_pkg::OPD_W'(r_pzz);
    assign w_tmag = (w_tilt < 0) ? -w_tilt : w_tilt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (f_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
        if (f_en) begin
            r_dx  <= i_data.goal_x - i_data.robot_x;
            r_dy  <= i_data.goal_y - i_data.robot_y;
            r_pxy <= i_data.quat_x * i_data.quat_y;
            r_pwz <= i_data.quat_w * i_data.quat_z;
            r_pww <= i_data.quat_w * i_data.quat_w;
            r_pxx <= i_data.quat_x * i_data.quat_x;
            r_pyy <= i_data.quat_y * i_data.quat_y;
            r_pzz <= i_data.quat_z * i_data.quat_z;
            r_pxz <= i_data.quat_x * i_data.quat_z;
            r_pwy <= i_data.quat_w * i_data.quat_y;
            r_job.dx       <= gtg_pkg::OPD_W'(r_dx);
            r_job.dy       <= gtg_pkg::OPD_W'(r_dy);
            r_job.num      <= w_num;
            r_job.den      <= w_den;
            r_job.yaw_zero <= (w_tmag >= w_norm);
        end
    end

endmodule

FILE: rtl/gtg_queue.sv
module gtg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gtg_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output gtg_pkg::t_job o_data
);

    gtg_pkg::t_job r_mem [gtg_pkg::QUEUE_DEPTH];
    logic [gtg_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [gtg_pkg::QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (gtg_pkg::QUEUE_AW+1)'(gtg_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("Queue read while empty.");

endmodule

FILE: rtl/gtg_atan.sv
module gtg_atan (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [gtg_pkg::OPD_W-1:0] i_x,
    input  logic signed [gtg_pkg::OPD_W-1:0] i_y,
    input  logic                             i_zero,
    output logic signed [gtg_pkg::ANG_W-1:0] o_angle
);

    localparam int W  = gtg_pkg::WIDE_W;
    localparam int AW = gtg_pkg::ANG_W;
    localparam int NS = gtg_pkg::NORM_STEPS;
    localparam int NC = gtg_pkg::CORDIC_ITERATIONS;

    logic signed [W-1:0]  w_ex, w_ey;
    logic signed [W-1:0]  r_px, r_py;
    logic signed [AW-1:0] r_pz;
    logic                 r_pzero;

    logic signed [W-1:0]  w_nx [0:NS];
    logic signed [W-1:0]  w_ny [0:NS];
    logic signed [AW-1:0] w_nz [0:NS];
    logic                 w_nzero [0:NS];

    logic signed [W-1:0]  w_cx [0:NC];
    logic signed [W-1:0]  w_cy [0:NC];
    logic signed [AW-1:0] w_cz [0:NC];
    logic                 w_czero [0:NC];

    assign w_ex = W'(i_x);
    assign w_ey = W'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pzero <= i_zero || (i_x == '0 && i_y == '0);
            if (w_ex < 0) begin
                if (w_ey >= 0) begin
                    r_px <= w_ey;
                    r_py <= -w_ex;
                    r_pz <= AW'(gtg_pkg::ANG_HALF_PI);
                end else begin
                    r_px <= -w_ey;
                    r_py <= w_ex;
                    r_pz <= -AW'(gtg_pkg::ANG_HALF_PI);
                end
            end else begin
                r_px <= w_ex;
                r_py <= w_ey;
                r_pz <= '0;
            end
        end
    end

    assign w_nx[0]    = r_px;
    assign w_ny[0]    = r_py;
    assign w_nz[0]    = r_pz;
    assign w_nzero[0] = r_pzero;

    // Binary search for the doubling count that lifts the larger magnitude into [2^59, 2^60).
    for (genvar g = 0; g < NS; g++) begin : g_norm
        localparam int SH = (1 << (NS - 1)) >> g;
        localparam logic signed [W-1:0] LIM = 64'sd1 <<< (gtg_pkg::NORM_EXP - SH);
        logic signed [W-1:0]  r_x, r_y;
        logic signed [AW-1:0] r_z;
        logic                 r_zero;
        logic                 w_small;
        assign w_small = (w_nx[g] < LIM) && (w_nx[g] > -LIM)
                      && (w_ny[g] < LIM) && (w_ny[g] > -LIM);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= w_small ? (w_nx[g] <<< SH) : w_nx[g];
                r_y    <= w_small ? (w_ny[g] <<< SH) : w_ny[g];
                r_z    <= w_nz[g];
                r_zero <= w_nzero[g];
            end
        end
        assign w_nx[g+1]    = r_x;
        assign w_ny[g+1]    = r_y;
        assign w_nz[g+1]    = r_z;
        assign w_nzero[g+1] = r_zero;
    end

    assign w_cx[0]    = w_nx[NS] <<< 1;
    assign w_cy[0]    = w_ny[NS] <<< 1;
    assign w_cz[0]    = w_nz[NS];
    assign w_czero[0] = w_nzero[NS];

    for (genvar i = 0; i < NC; i++) begin : g_rot
        localparam logic signed [AW-1:0] STEP = $signed(AW'(gtg_pkg::ATAN_TAB[i]));
        logic signed [W-1:0]  r_x, r_y;
        logic signed [AW-1:0] r_z;
        logic                 r_zero;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero <= w_czero[i];
                if (w_cy[i] > 0) begin
                    r_x <= w_cx[i] + (w_cy[i] >>> i);
                    r_y <= w_cy[i] - (w_cx[i] >>> i);
                    r_z <= w_cz[i] + STEP;
                end else begin
                    r_x <= w_cx[i] - (w_cy[i] >>> i);
                    r_y <= w_cy[i] + (w_cx[i] >>> i);
                    r_z <= w_cz[i] - STEP;
                end
            end
        end
        assign w_cx[i+1]    = r_x;
        assign w_cy[i+1]    = r_y;
        assign w_cz[i+1]    = r_z;
        assign w_czero[i+1] = r_zero;
    end

    assign o_angle = w_czero[NC] ? '0 : w_cz[NC];

endmodule

FILE: rtl/gtg_back.sv
module gtg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gtg_pkg::t_cfg      i_cfg,
    input  logic               i_job_valid,
    input  gtg_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output gtg_pkg::t_out_beat o_data
);

    localparam int LAT = gtg_pkg::BACK_LAT;
    localparam int DW  = gtg_pkg::DIFF_W;
    localparam int RW  = gtg_pkg::RATE_W;
    localparam int SQ  = gtg_pkg::SQ_STEPS;
    localparam int DV  = gtg_pkg::DIV_STEPS;
    localparam int QW  = gtg_pkg::SQ_ROOT_W;
    localparam int MW  = gtg_pkg::SQ_REM_W;
    localparam int VW  = gtg_pkg::DIV_REM_W;
    localparam int NW  = gtg_pkg::DIV_NUM_W;
    localparam int EHW = gtg_pkg::ERR_W - gtg_pkg::ERR_LO_W;
    localparam logic signed [DW-1:0] C_PI     = DW'(gtg_pkg::ANG_PI);
    localparam logic signed [DW-1:0] C_TWO_PI = DW'(gtg_pkg::ANG_TWO_PI);

    logic pipe_en;
    logic [LAT-1:0] r_vld;
    logic r_out_valid;
    gtg_pkg::t_out_beat r_out;

    logic signed [gtg_pkg::ANG_W-1:0] w_bear, w_yaw;
    logic signed [DW-1:0]  r_d;
    logic signed [gtg_pkg::ERR_W-1:0] r_err;
    logic signed [gtg_pkg::KP_W+EHW:0] r_phi;
    logic [gtg_pkg::KP_W+gtg_pkg::ERR_LO_W-1:0] r_plo;
    logic signed [EHW-1:0] w_err_hi;
    logic signed [gtg_pkg::SUM_W-1:0] w_sum;
    logic signed [RW-1:0]  r_ang, r_a_ang, w_abs;
    logic [gtg_pkg::SQ_N_W-1:0] r_a_n;

    logic [MW-1:0]              w_sq_rem  [0:SQ];
    logic [QW-1:0]              w_sq_root [0:SQ];
    logic [gtg_pkg::SQ_N_W-1:0] w_sq_n    [0:SQ];
    logic signed [RW-1:0]       w_sq_ang  [0:SQ];

    logic [NW-1:0]        w_dnum;
    logic [VW-1:0]        w_dv_rem [0:DV];
    logic [DV-1:0]        w_dv_low [0:DV];
    logic [DV-1:0]        w_dv_q   [0:DV];
    logic [QW-1:0]        w_dv_s   [0:DV];
    logic signed [RW-1:0] w_dv_ang [0:DV];
    logic [VW-1:0]        r_d0_rem;
    logic [DV-1:0]        r_d0_low;
    logic [QW-1:0]        r_d0_s;
    logic signed [RW-1:0] r_d0_ang;

    logic signed [RW-1:0] w_amax, w_ang_c;
    logic [DV-1:0]        w_lin_c;

    assign pipe_en = !r_out_valid || i_ready;
    assign o_pop   = pipe_en && i_job_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    gtg_atan u_bearing (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_x     (i_job.dx),
        .i_y     (i_job.dy),
        .i_zero  (1'b0),
        .o_angle (w_bear)
    );

    gtg_atan u_yaw (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_x     (i_job.den),
        .i_y     (i_job.num),
        .i_zero  (i_job.yaw_zero),
        .o_angle (w_yaw)
    );

    assign w_err_hi = r_err[gtg_pkg::ERR_W-1:gtg_pkg::ERR_LO_W];
    assign w_sum = (gtg_pkg::SUM_W'(r_phi) <<< gtg_pkg::ERR_LO_W)
                 + $signed(gtg_pkg::SUM_W'(r_plo))
                 + (gtg_pkg::SUM_W'(1) <<< (gtg_pkg::RATE_SHIFT - 1));
    assign w_abs = (r_ang < 0) ? -r_ang : r_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_vld       <= {r_vld[LAT-2:0], i_job_valid};
            r_out_valid <= r_vld[LAT-1];
        end
        if (pipe_en) begin
            r_d <= DW'(w_bear) - DW'(w_yaw);
            if (r_d > C_PI) begin
                r_err <= gtg_pkg::ERR_W'(r_d - C_TWO_PI);
            end else if (r_d < -C_PI) begin
                r_err <= gtg_pkg::ERR_W'(r_d + C_TWO_PI);
            end else begin
                r_err <= gtg_pkg::ERR_W'(r_d);
            end
            r_phi   <= $signed({1'b0, i_cfg.kp}) * w_err_hi;
            r_plo   <= i_cfg.kp * r_err[gtg_pkg::ERR_LO_W-1:0];
            r_ang   <= w_sum[gtg_pkg::SUM_W-1:gtg_pkg::RATE_SHIFT];
            r_a_ang <= r_ang;
            r_a_n   <= gtg_pkg::SQ_N_W'({w_abs + (RW'(1) <<< gtg_pkg::FRAC_W),
                                         gtg_pkg::FRAC_W'(0)});
            r_d0_rem <= VW'(w_dnum[NW-1:DV]);
            r_d0_low <= w_dnum[DV-1:0];
            r_d0_s   <= w_sq_root[SQ];
            r_d0_ang <= w_sq_ang[SQ];
            r_out.linear_velocity  <= gtg_pkg::VEL_W'(w_lin_c);
            r_out.angular_velocity <= gtg_pkg::VEL_W'(w_ang_c);
        end
    end

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_n[0]    = r_a_n;
    assign w_sq_ang[0]  = r_a_ang;

    // Restoring square root, one result bit per stage.
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        logic [MW+1:0] w_r2, w_trial;
        logic [MW-1:0] r_rem;
        logic [QW-1:0] r_root;
        logic [gtg_pkg::SQ_N_W-1:0] r_n;
        logic signed [RW-1:0] r_a;
        assign w_r2    = {w_sq_rem[k], w_sq_n[k][gtg_pkg::SQ_N_W-1 -: 2]};
        assign w_trial = (MW+2)'({w_sq_root[k], 2'b01});
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_n <= w_sq_n[k] << 2;
                r_a <= w_sq_ang[k];
                if (w_r2 >= w_trial) begin
                    r_rem  <= MW'(w_r2 - w_trial);
                    r_root <= {w_sq_root[k][QW-2:0], 1'b1};
                end else begin
                    r_rem  <= MW'(w_r2);
                    r_root <= {w_sq_root[k][QW-2:0], 1'b0};
                end
            end
        end
        assign w_sq_rem[k+1]  = r_rem;
        assign w_sq_root[k+1] = r_root;
        assign w_sq_n[k+1]    = r_n;
        assign w_sq_ang[k+1]  = r_a;
    end

    assign w_dnum = NW'({i_cfg.lmax, gtg_pkg::FRAC_W'(0)}) + NW'(w_sq_root[SQ] >> 1);

    assign w_dv_rem[0] = r_d0_rem;
    assign w_dv_low[0] = r_d0_low;
    assign w_dv_q[0]   = '0;
    assign w_dv_s[0]   = r_d0_s;
    assign w_dv_ang[0] = r_d0_ang;

    // Restoring division, one quotient bit per stage.
    for (genvar j = 0; j < DV; j++) begin : g_div
        logic [VW:0]   w_r2;
        logic [VW-1:0] r_rem;
        logic [DV-1:0] r_low, r_q;
        logic [QW-1:0] r_s;
        logic signed [RW-1:0] r_a;
        assign w_r2 = {w_dv_rem[j], w_dv_low[j][DV-1]};
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_low <= w_dv_low[j] << 1;
                r_s   <= w_dv_s[j];
                r_a   <= w_dv_ang[j];
                if (w_r2 >= (VW+1)'(w_dv_s[j])) begin
                    r_rem <= VW'(w_r2 - (VW+1)'(w_dv_s[j]));
                    r_q   <= {w_dv_q[j][DV-2:0], 1'b1};
                end else begin
                    r_rem <= VW'(w_r2);
                    r_q   <= {w_dv_q[j][DV-2:0], 1'b0};
                end
            end
        end
        assign w_dv_rem[j+1] = r_rem;
        assign w_dv_low[j+1] = r_low;
        assign w_dv_q[j+1]   = r_q;
        assign w_dv_s[j+1]   = r_s;
        assign w_dv_ang[j+1] = r_a;
    end

    assign w_amax  = $signed(RW'(i_cfg.amax));
    assign w_ang_c = (w_dv_ang[DV] > w_amax)  ? w_amax  :
                     (w_dv_ang[DV] < -w_amax) ? -w_amax : w_dv_ang[DV];
    assign w_lin_c = (w_dv_q[DV] > DV'(i_cfg.lmax)) ? DV'(i_cfg.lmax) : w_dv_q[DV];

endmodule

FILE: rtl/go_to_goal_velocity_controller_core.sv
// Proportional go-to-goal controller: each beat carries a goal position and a robot pose,
// and yields one beat with the forward speed and turn rate. A new pose is accepted every
// cycle while o_ready is high; items flow through a two-stage front end, a four-entry queue
// and a fixed back-end pipeline of 1 + 6 + CORDIC_ITERATIONS stages for the two parallel
// atan2 units, 5 stages of heading error and gain multiply, 23 square-root stages, a
// staging register and the divider stages, plus the output register.
// Registers may be written only while no item is in flight.
module go_to_goal_velocity_controller_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  gtg_pkg::t_in_beat         i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output gtg_pkg::t_out_beat        o_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [gtg_pkg::CFG_W-1:0] i_cfg_data
);

    gtg_pkg::t_cfg r_cfg;
    gtg_pkg::t_job w_f_job, w_q_job;
    logic w_push, w_full, w_pop, w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp   <= gtg_pkg::KP_W'(65536);
            r_cfg.lmax <= gtg_pkg::SPD_W'(32768);
            r_cfg.amax <= gtg_pkg::SPD_W'(65536);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gtg_pkg::CFG_KP:   r_cfg.kp   <= i_cfg_data[gtg_pkg::KP_W-1:0];
                gtg_pkg::CFG_LMAX: r_cfg.lmax <= i_cfg_data[gtg_pkg::SPD_W-1:0];
                gtg_pkg::CFG_AMAX: r_cfg.amax <= i_cfg_data[gtg_pkg::SPD_W-1:0];
                default: ;
            endcase
        end
    end

    gtg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_job   (w_f_job)
    );

    gtg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_f_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_q_job)
    );

    gtg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (!w_empty),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output beat valid right after reset.");

    a_ang_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_data.angular_velocity) <= $signed({1'b0, r_cfg.amax}))
                 && ($signed(o_data.angular_velocity) >= -$signed({1'b0, r_cfg.amax})))
        else $error("Turn rate outside its limit.");

    a_lin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_data.linear_velocity) >= 0)
                 && ($signed(o_data.linear_velocity) <= $signed({1'b0, r_cfg.lmax})))
        else $error("Forward speed outside its limit.");

endmodule
